### rtl/refcounted_handle_pool_core_defines.svh
// ----------------------------------------------------------------------------
// refcounted handle pool assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_POOL_CORE_DEFINES_SVH
`define REFCOUNTED_HANDLE_POOL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define HPOOL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define HPOOL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPOOL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HPOOL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/hpool_pkg.sv
// ----------------------------------------------------------------------------
// hpool_pkg
// shared widths, codes and types of the handle pool
// ----------------------------------------------------------------------------
package hpool_pkg;

    localparam int HANDLE_W = 20;
    localparam int COUNT_W  = 11;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 4;
    localparam int OP_W     = 3;

    localparam int ENTRIES_DEF    = 256;
    localparam int ID_BITS_DEF    = 20;
    localparam int COUNT_BITS_DEF = 11;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC       = 3'd0,
        OP_ALLOC_LOCK  = 3'd1,
        OP_FREE        = 3'd2,
        OP_LOCK_FIRST  = 3'd3,
        OP_LOCK        = 3'd4,
        OP_UNLOCK      = 3'd5,
        OP_UNLOCK_LAST = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_FULL      = 4'd1,
        ST_INVALID   = 4'd2,
        ST_STALE     = 4'd3,
        ST_NOTALLOC  = 4'd4,
        ST_NOTLOCKED = 4'd5,
        ST_LOCKED    = 4'd6,
        ST_SAT       = 4'd7,
        ST_NOTLAST   = 4'd8
    } status_t;

    typedef struct packed {
        status_t status;
        logic    hit;
        logic    wr_en;
        logic    new_alloc;
        logic    slot_valid;
        logic    freed;
    } eval_flags_t;

endpackage

### rtl/refcounted_handle_pool_core.sv
// ----------------------------------------------------------------------------
// refcounted_handle_pool_core: generational handle pool with reference counts
// handle ops: a new request is accepted only once the previous result is registered
// alloc: one candidate slot per cycle through the header memory read port,
//   at most ENTRIES candidates per request
// after reset a clearing pass writes every slot header before the first beat
// ----------------------------------------------------------------------------
`include "refcounted_handle_pool_core_defines.svh"

module refcounted_handle_pool_core #(
    parameter int ENTRIES    = hpool_pkg::ENTRIES_DEF,
    parameter int ID_BITS    = hpool_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = hpool_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hpool_pkg::OP_W-1:0]     opcode,
    input  logic [hpool_pkg::HANDLE_W-1:0] handle,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hpool_pkg::STATUS_W-1:0] status,
    output logic [hpool_pkg::HANDLE_W-1:0] handle_out,
    output logic [hpool_pkg::SLOT_W-1:0]   slot_index,
    output logic [hpool_pkg::COUNT_W-1:0]  ref_count,
    output logic                           freed
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int EXT_W = (ID_BITS > IDX_W) ? ID_BITS : IDX_W;
    localparam int HDR_W = 1 + COUNT_BITS + ID_BITS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    function automatic logic [IDX_W-1:0] idx_of(input logic [ID_BITS-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[IDX_W-1:0];
    endfunction

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               clr_idx_reg, clr_idx_next;
    logic [hpool_pkg::OP_W-1:0]     op_reg, op_next;
    logic [ID_BITS-1:0]             id_reg, id_next;
    logic [IDX_W-1:0]               scan_cnt_reg, scan_cnt_next;
    logic [ID_BITS-1:0]             next_cand_reg, next_cand_next;
    logic                           out_valid_reg, out_valid_next;
    logic [hpool_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [hpool_pkg::HANDLE_W-1:0] handle_out_reg, handle_out_next;
    logic [hpool_pkg::SLOT_W-1:0]   slot_index_reg, slot_index_next;
    logic [hpool_pkg::COUNT_W-1:0]  ref_count_reg, ref_count_next;
    logic                           freed_reg, freed_next;

    logic                   in_beat;
    logic                   in_is_alloc;
    logic                   is_alloc;
    logic [ID_BITS-1:0]     in_id;
    logic [ID_BITS-1:0]     cand_step;
    logic [IDX_W-1:0]       idx_cur;
    logic                   done;
    logic                   out_free;
    logic                   finish;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [HDR_W-1:0]       ram_wr_data;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [HDR_W-1:0]       ram_rd_data;

    hpool_pkg::eval_flags_t flags;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [COUNT_BITS-1:0]  out_cnt;

    hpool_hdr_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (HDR_W)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    hpool_eval #(
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_eval (
        .op        (op_reg),
        .id        (id_reg),
        .hdr_alloc (ram_rd_data[HDR_W-1]),
        .hdr_cnt   (ram_rd_data[HDR_W-2:ID_BITS]),
        .hdr_id    (ram_rd_data[ID_BITS-1:0]),
        .flags     (flags),
        .new_cnt   (new_cnt),
        .out_cnt   (out_cnt)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign in_beat     = in_valid && !in_stall;
    assign in_is_alloc = (opcode == hpool_pkg::OP_ALLOC) || (opcode == hpool_pkg::OP_ALLOC_LOCK);
    assign in_id       = in_is_alloc ? next_cand_reg : ID_BITS'(handle);
    assign is_alloc    = (op_reg == hpool_pkg::OP_ALLOC) || (op_reg == hpool_pkg::OP_ALLOC_LOCK);
    assign cand_step   = id_reg + ID_BITS'(1);
    assign idx_cur     = idx_of(id_reg);
    assign done        = !is_alloc || flags.hit || (scan_cnt_reg == IDX_W'(ENTRIES - 1));
    assign out_free    = !out_valid_reg || !out_stall;
    assign finish      = (state_reg == S_LOOK) && done && out_free;

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_cur;
        ram_wr_data = {flags.new_alloc, new_cnt, id_reg};
        ram_rd_addr = idx_cur;
        if (state_reg == S_CLEAR)
        begin
            // slot 0 stays allocated with the invalid id
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_reg;
            ram_wr_data = {(clr_idx_reg == '0), {(COUNT_BITS + ID_BITS){1'b0}}};
        end
        else if (finish)
        begin
            ram_wr_en = flags.wr_en;
        end
        if (state_reg == S_IDLE)
        begin
            ram_rd_addr = idx_of(in_id);
        end
        else if (state_reg == S_LOOK && !done)
        begin
            ram_rd_addr = idx_of(cand_step);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        scan_cnt_next   = scan_cnt_reg;
        next_cand_next  = next_cand_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        handle_out_next = handle_out_reg;
        slot_index_next = slot_index_reg;
        ref_count_next  = ref_count_reg;
        freed_next      = freed_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next       = opcode;
                    id_next       = in_id;
                    scan_cnt_next = '0;
                    state_next    = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!done)
                begin
                    id_next       = cand_step;
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = flags.status;
                    handle_out_next = flags.hit ? hpool_pkg::HANDLE_W'(id_reg) : '0;
                    slot_index_next = flags.slot_valid ? hpool_pkg::SLOT_W'(idx_cur) : '0;
                    ref_count_next  = hpool_pkg::COUNT_W'(out_cnt);
                    freed_next      = flags.freed;
                    if (flags.hit)
                    begin
                        next_cand_next = cand_step;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            op_reg         <= '0;
            id_reg         <= '0;
            scan_cnt_reg   <= '0;
            next_cand_reg  <= ID_BITS'(1);
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            handle_out_reg <= '0;
            slot_index_reg <= '0;
            ref_count_reg  <= '0;
            freed_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            scan_cnt_reg   <= scan_cnt_next;
            next_cand_reg  <= next_cand_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            handle_out_reg <= handle_out_next;
            slot_index_reg <= slot_index_next;
            ref_count_reg  <= ref_count_next;
            freed_reg      <= freed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign slot_index = slot_index_reg;
    assign ref_count  = ref_count_reg;
    assign freed      = freed_reg;

    `HPOOL_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && out_stall, out_valid_reg, "stalled result beat dropped")
    `HPOOL_ASSERT_IMP(a_freed_ok, clk, rst_n, out_valid_reg && freed_reg, status_reg == hpool_pkg::ST_OK && ref_count_reg == '0, "freed without a final unlock")
    `HPOOL_ASSERT_IMP(a_handle_ok, clk, rst_n, out_valid_reg && handle_out_reg != '0, status_reg == hpool_pkg::ST_OK && ref_count_reg < hpool_pkg::COUNT_W'(2), "handle returned outside a good allocation")

endmodule

### rtl/hpool_hdr_ram.sv
// ----------------------------------------------------------------------------
// hpool_hdr_ram
// slot header memory, one write and one registered read port
// ----------------------------------------------------------------------------
module hpool_hdr_ram #(
    parameter int DEPTH = hpool_pkg::ENTRIES_DEF,
    parameter int WIDTH = 1 + hpool_pkg::COUNT_BITS_DEF + hpool_pkg::ID_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/hpool_eval.sv
// ----------------------------------------------------------------------------
// hpool_eval
// checks one slot header against a request and forms the updated header
// ----------------------------------------------------------------------------
module hpool_eval #(
    parameter int ID_BITS    = hpool_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = hpool_pkg::COUNT_BITS_DEF
) (
    input  logic [hpool_pkg::OP_W-1:0] op,
    input  logic [ID_BITS-1:0]         id,
    input  logic                       hdr_alloc,
    input  logic [COUNT_BITS-1:0]      hdr_cnt,
    input  logic [ID_BITS-1:0]         hdr_id,
    output hpool_pkg::eval_flags_t     flags,
    output logic [COUNT_BITS-1:0]      new_cnt,
    output logic [COUNT_BITS-1:0]      out_cnt
);

    logic id_match;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_max;

    assign id_match = (hdr_id == id);
    assign cnt_zero = (hdr_cnt == '0);
    assign cnt_one  = (hdr_cnt == COUNT_BITS'(1));
    assign cnt_max  = &hdr_cnt;

    always_comb
    begin
        flags.status     = hpool_pkg::ST_INVALID;
        flags.hit        = 1'b0;
        flags.wr_en      = 1'b0;
        flags.new_alloc  = 1'b1;
        flags.slot_valid = 1'b0;
        flags.freed      = 1'b0;
        new_cnt          = hdr_cnt;
        out_cnt          = '0;
        unique case (op) inside
            hpool_pkg::OP_ALLOC, hpool_pkg::OP_ALLOC_LOCK:
            begin
                if (id != '0 && !hdr_alloc && !id_match)
                begin
                    flags.status     = hpool_pkg::ST_OK;
                    flags.hit        = 1'b1;
                    flags.wr_en      = 1'b1;
                    flags.slot_valid = 1'b1;
                    new_cnt = (op == hpool_pkg::OP_ALLOC_LOCK) ? COUNT_BITS'(1) : '0;
                    out_cnt = new_cnt;
                end
                else
                begin
                    flags.status = hpool_pkg::ST_FULL;
                end
            end
            hpool_pkg::OP_FREE, hpool_pkg::OP_LOCK_FIRST, hpool_pkg::OP_LOCK,
            hpool_pkg::OP_UNLOCK, hpool_pkg::OP_UNLOCK_LAST:
            begin
                if (id != '0)
                begin
                    flags.slot_valid = 1'b1;
                    out_cnt          = hdr_cnt;
                    if (!id_match)
                    begin
                        flags.status = hpool_pkg::ST_STALE;
                    end
                    else if (!hdr_alloc)
                    begin
                        flags.status = hpool_pkg::ST_NOTALLOC;
                    end
                    else
                    begin
                        case (op)
                            hpool_pkg::OP_FREE:
                            begin
                                if (!cnt_zero)
                                begin
                                    flags.status = hpool_pkg::ST_LOCKED;
                                end
                                else
                                begin
                                    flags.status    = hpool_pkg::ST_OK;
                                    flags.wr_en     = 1'b1;
                                    flags.new_alloc = 1'b0;
                                    new_cnt         = '0;
                                    out_cnt         = '0;
                                end
                            end
                            hpool_pkg::OP_LOCK_FIRST:
                            begin
                                if (!cnt_zero)
                                begin
                                    flags.status = hpool_pkg::ST_LOCKED;
                                end
                                else
                                begin
                                    flags.status = hpool_pkg::ST_OK;
                                    flags.wr_en  = 1'b1;
                                    new_cnt      = COUNT_BITS'(1);
                                    out_cnt      = COUNT_BITS'(1);
                                end
                            end
                            hpool_pkg::OP_LOCK:
                            begin
                                if (cnt_zero)
                                begin
                                    flags.status = hpool_pkg::ST_NOTLOCKED;
                                end
                                else if (cnt_max)
                                begin
                                    flags.status = hpool_pkg::ST_SAT;
                                end
                                else
                                begin
                                    flags.status = hpool_pkg::ST_OK;
                                    flags.wr_en  = 1'b1;
                                    new_cnt      = hdr_cnt + COUNT_BITS'(1);
                                    out_cnt      = new_cnt;
                                end
                            end
                            default:
                            begin
                                if (cnt_zero)
                                begin
                                    flags.status = hpool_pkg::ST_NOTLOCKED;
                                end
                                else if (op == hpool_pkg::OP_UNLOCK_LAST && !cnt_one)
                                begin
                                    flags.status = hpool_pkg::ST_NOTLAST;
                                end
                                else
                                begin
                                    // drop one reference; the last one frees the slot
                                    flags.status    = hpool_pkg::ST_OK;
                                    flags.wr_en     = 1'b1;
                                    flags.new_alloc = !cnt_one;
                                    flags.freed     = cnt_one;
                                    new_cnt         = hdr_cnt - COUNT_BITS'(1);
                                    out_cnt         = new_cnt;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                flags.status = hpool_pkg::ST_INVALID;
            end
        endcase
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: refcounted handle pool regression
// drives allocate, lock, unlock and free requests through the valid/stall
// request port and checks every result beat against a cycle-free model of
// the slot table. runs directed corner cases, a long result hold-off, a full
// fill and drain of the pool and random mixes under several idling patterns
// ----------------------------------------------------------------------------
module tb;

    localparam int ENTRIES = hpool_pkg::ENTRIES_DEF;
    localparam logic [hpool_pkg::COUNT_W-1:0] REFS_MAX = '1;
    localparam logic [hpool_pkg::OP_W-1:0] OP_UNKNOWN = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic                           used;
        logic [hpool_pkg::COUNT_W-1:0]  refs;
        logic [hpool_pkg::HANDLE_W-1:0] gen_id;
    } slot_hdr_t;

    typedef struct packed {
        hpool_pkg::status_t             status;
        logic [hpool_pkg::HANDLE_W-1:0] handle_out;
        logic [hpool_pkg::SLOT_W-1:0]   slot;
        logic [hpool_pkg::COUNT_W-1:0]  refs;
        logic                           freed;
    } pool_result_t;

    typedef struct packed {
        logic [hpool_pkg::OP_W-1:0]     code;
        logic [hpool_pkg::HANDLE_W-1:0] id;
    } pool_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [hpool_pkg::OP_W-1:0] opcode = '0;
    logic [hpool_pkg::HANDLE_W-1:0] handle = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [hpool_pkg::STATUS_W-1:0] status;
    logic [hpool_pkg::HANDLE_W-1:0] handle_out;
    logic [hpool_pkg::SLOT_W-1:0] slot_index;
    logic [hpool_pkg::COUNT_W-1:0] ref_count;
    logic freed;

    // model 0 tracks the stimulus as it is generated, model 1 the accepted beats
    slot_hdr_t pool_hdr [0:2*ENTRIES-1];
    logic [hpool_pkg::HANDLE_W-1:0] pool_next_id [0:1];

    pool_req_t pending_requests [$];
    pool_result_t predicted_results [$];
    logic [hpool_pkg::HANDLE_W-1:0] live_ids [$];
    logic [hpool_pkg::HANDLE_W-1:0] retired_ids [$];

    pool_req_t beat;
    pool_result_t want;
    logic in_accepted = 1'b0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int status_seen [0:15];

    refcounted_handle_pool_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out),
        .slot_index (slot_index),
        .ref_count  (ref_count),
        .freed      (freed)
    );

    always #5 clk = ~clk;

    function automatic pool_result_t apply_pool_op(input int m,
                                                   input logic [hpool_pkg::OP_W-1:0] code,
                                                   input logic [hpool_pkg::HANDLE_W-1:0] id);
        pool_result_t r;
        slot_hdr_t cur;
        logic [hpool_pkg::HANDLE_W-1:0] cand;
        logic [hpool_pkg::SLOT_W-1:0] idx;
        logic hit;
        int n;
        r = '0;
        r.status = hpool_pkg::ST_OK;
        if (code == hpool_pkg::OP_ALLOC || code == hpool_pkg::OP_ALLOC_LOCK)
        begin
            cand = pool_next_id[m];
            hit = 1'b0;
            r.status = hpool_pkg::ST_FULL;
            for (n = 0; n < ENTRIES && !hit; n++)
            begin
                cur = pool_hdr[m*ENTRIES + cand[hpool_pkg::SLOT_W-1:0]];
                if (cand != 0 && !cur.used && cur.gen_id != cand)
                begin
                    hit = 1'b1;
                    cur.used = 1'b1;
                    cur.refs = (code == hpool_pkg::OP_ALLOC_LOCK) ?
                               hpool_pkg::COUNT_W'(1) : '0;
                    cur.gen_id = cand;
                    pool_hdr[m*ENTRIES + cand[hpool_pkg::SLOT_W-1:0]] = cur;
                    pool_next_id[m] = cand + 1'b1;
                    r.status = hpool_pkg::ST_OK;
                    r.handle_out = cand;
                    r.slot = cand[hpool_pkg::SLOT_W-1:0];
                    r.refs = cur.refs;
                end
                else
                begin
                    cand = cand + 1'b1;
                end
            end
            return r;
        end
        if (code == OP_UNKNOWN || id == 0)
        begin
            r.status = hpool_pkg::ST_INVALID;
            return r;
        end
        idx = id[hpool_pkg::SLOT_W-1:0];
        cur = pool_hdr[m*ENTRIES + idx];
        r.slot = idx;
        r.refs = cur.refs;
        if (cur.gen_id != id)
            r.status = hpool_pkg::ST_STALE;
        else if (!cur.used)
            r.status = hpool_pkg::ST_NOTALLOC;
        else
        begin
            case (code)
                hpool_pkg::OP_FREE:
                    if (cur.refs != 0)
                        r.status = hpool_pkg::ST_LOCKED;
                    else
                        cur.used = 1'b0;
                hpool_pkg::OP_LOCK_FIRST:
                    if (cur.refs != 0)
                        r.status = hpool_pkg::ST_LOCKED;
                    else
                        cur.refs = hpool_pkg::COUNT_W'(1);
                hpool_pkg::OP_LOCK:
                    if (cur.refs == 0)
                        r.status = hpool_pkg::ST_NOTLOCKED;
                    else if (cur.refs == REFS_MAX)
                        r.status = hpool_pkg::ST_SAT;
                    else
                        cur.refs = cur.refs + 1'b1;
                default:
                    if (cur.refs == 0)
                        r.status = hpool_pkg::ST_NOTLOCKED;
                    else if (code == hpool_pkg::OP_UNLOCK_LAST && cur.refs != 1)
                        r.status = hpool_pkg::ST_NOTLAST;
                    else
                    begin
                        r.freed = (cur.refs == 1);
                        cur.used = (cur.refs != 1);
                        cur.refs = cur.refs - 1'b1;
                    end
            endcase
            r.refs = cur.refs;
            pool_hdr[m*ENTRIES + idx] = cur;
        end
        return r;
    endfunction

    task automatic queue_op(input logic [hpool_pkg::OP_W-1:0] code,
                            input logic [hpool_pkg::HANDLE_W-1:0] id,
                            output pool_result_t r);
        int k;
        r = apply_pool_op(0, code, id);
        pending_requests.push_back('{code: code, id: id});
        n_queued++;
        if ((code == hpool_pkg::OP_ALLOC || code == hpool_pkg::OP_ALLOC_LOCK) &&
            r.status == hpool_pkg::ST_OK)
            live_ids.push_back(r.handle_out);
        if (r.status == hpool_pkg::ST_OK && (r.freed || code == hpool_pkg::OP_FREE))
        begin
            for (k = live_ids.size() - 1; k >= 0; k--)
                if (live_ids[k] == id)
                    live_ids.delete(k);
            retired_ids.push_back(id);
            if (retired_ids.size() > 32)
                void'(retired_ids.pop_front());
        end
    endtask

    // mostly well-formed traffic on live handles, plus stale, invalid and noise beats
    task automatic random_burst(input int count);
        int i;
        int roll;
        int pick;
        logic [hpool_pkg::OP_W-1:0] code;
        logic [hpool_pkg::HANDLE_W-1:0] id;
        pool_result_t r;
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                code = hpool_pkg::OP_W'($urandom_range(OP_UNKNOWN));
                id = hpool_pkg::HANDLE_W'($urandom);
            end
            else if (roll < 14 && retired_ids.size() > 0)
            begin
                code = hpool_pkg::OP_W'($urandom_range(hpool_pkg::OP_UNLOCK_LAST,
                                                       hpool_pkg::OP_FREE));
                id = retired_ids[$urandom_range(retired_ids.size() - 1)];
            end
            else if (roll < 16)
            begin
                code = hpool_pkg::OP_W'($urandom_range(OP_UNKNOWN, hpool_pkg::OP_FREE));
                id = '0;
            end
            else if (live_ids.size() < 3 || (live_ids.size() < 40 && roll < 36))
            begin
                code = $urandom_range(1) ? hpool_pkg::OP_ALLOC_LOCK : hpool_pkg::OP_ALLOC;
                id = hpool_pkg::HANDLE_W'($urandom);
            end
            else
            begin
                pick = $urandom_range(live_ids.size() - 1);
                id = live_ids[pick];
                roll = $urandom_range(99);
                if (roll < 25)
                    code = hpool_pkg::OP_LOCK;
                else if (roll < 50)
                    code = hpool_pkg::OP_UNLOCK;
                else if (roll < 62)
                    code = hpool_pkg::OP_UNLOCK_LAST;
                else if (roll < 77)
                    code = hpool_pkg::OP_LOCK_FIRST;
                else
                    code = hpool_pkg::OP_FREE;
            end
            queue_op(code, id, r);
        end
    endtask

    task automatic wait_idle();
        while (n_checked != n_queued)
            @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_accepted))
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                beat = pending_requests.pop_front();
                in_valid <= 1'b1;
                opcode <= beat.code;
                handle <= beat.id;
            end
            else
            begin
                in_valid <= 1'b0;
                opcode <= hpool_pkg::OP_W'($urandom);
                handle <= hpool_pkg::HANDLE_W'($urandom);
            end
        end
    end

    // result stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_accepted <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    n_checked <= n_checked + 1;
                    status_seen[want.status]++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                    if (handle_out !== want.handle_out)
                    begin
                        $error("handle_out: expected %0h, actual %0h",
                               want.handle_out, handle_out);
                        errors++;
                    end
                    if (slot_index !== want.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
                        errors++;
                    end
                    if (ref_count !== want.refs)
                    begin
                        $error("ref_count: expected %0d, actual %0d", want.refs, ref_count);
                        errors++;
                    end
                    if (freed !== want.freed)
                    begin
                        $error("freed: expected %0d, actual %0d", want.freed, freed);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted_results.push_back(apply_pool_op(1, opcode, handle));
                n_accepted++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("refcounted_handle_pool_core regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        pool_result_t r;
        logic [hpool_pkg::HANDLE_W-1:0] first_id;
        logic [hpool_pkg::HANDLE_W-1:0] id;
        int i;
        int fulls;
        int pick;
        for (i = 0; i < 16; i++)
            status_seen[i] = 0;
        for (i = 0; i < 2*ENTRIES; i++)
            pool_hdr[i] = '0;
        pool_hdr[0].used = 1'b1;
        pool_hdr[ENTRIES].used = 1'b1;
        pool_next_id[0] = hpool_pkg::HANDLE_W'(1);
        pool_next_id[1] = hpool_pkg::HANDLE_W'(1);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        queue_op(hpool_pkg::OP_LOCK, '0, r);
        queue_op(OP_UNKNOWN, '1, r);
        queue_op(OP_UNKNOWN, '0, r);
        queue_op(hpool_pkg::OP_FREE, hpool_pkg::HANDLE_W'(ENTRIES), r);
        queue_op(hpool_pkg::OP_LOCK_FIRST, '1, r);
        queue_op(hpool_pkg::OP_ALLOC, '1, r);
        first_id = r.handle_out;
        queue_op(hpool_pkg::OP_LOCK, first_id, r);
        queue_op(hpool_pkg::OP_UNLOCK, first_id, r);
        queue_op(hpool_pkg::OP_UNLOCK_LAST, first_id, r);
        queue_op(hpool_pkg::OP_LOCK_FIRST, first_id, r);
        queue_op(hpool_pkg::OP_LOCK_FIRST, first_id, r);
        queue_op(hpool_pkg::OP_FREE, first_id, r);
        queue_op(hpool_pkg::OP_LOCK, first_id, r);
        queue_op(hpool_pkg::OP_UNLOCK_LAST, first_id, r);
        queue_op(hpool_pkg::OP_UNLOCK, first_id, r);
        queue_op(hpool_pkg::OP_UNLOCK_LAST, first_id, r);
        queue_op(hpool_pkg::OP_LOCK, first_id, r);
        queue_op(hpool_pkg::OP_FREE, first_id, r);
        queue_op(hpool_pkg::OP_ALLOC_LOCK, '0, r);
        queue_op(hpool_pkg::OP_UNLOCK, r.handle_out, r);
        queue_op(hpool_pkg::OP_ALLOC, '0, r);
        queue_op(hpool_pkg::OP_FREE, r.handle_out, r);
        queue_op(hpool_pkg::OP_LOCK, first_id + hpool_pkg::HANDLE_W'(ENTRIES), r);
        wait_idle();

        // back-to-back traffic under a long result hold-off
        hold_go = 1'b1;
        random_burst(80);
        wait_idle();

        send_idle_pct = 84;
        random_burst(50);
        wait_idle();

        send_idle_pct = 0;
        stall_pct = 84;
        random_burst(50);
        wait_idle();

        // both sides idling, then fill the pool and drain it again
        send_idle_pct = 37;
        stall_pct = 37;
        random_burst(50);
        fulls = 0;
        while (fulls < 3)
        begin
            queue_op($urandom_range(1) ? hpool_pkg::OP_ALLOC_LOCK : hpool_pkg::OP_ALLOC,
                     hpool_pkg::HANDLE_W'($urandom), r);
            if (r.status == hpool_pkg::ST_FULL)
                fulls++;
        end
        while (live_ids.size() > 0)
        begin
            pick = $urandom_range(live_ids.size() - 1);
            id = live_ids[pick];
            if (pool_hdr[id[hpool_pkg::SLOT_W-1:0]].refs == 0)
                queue_op(hpool_pkg::OP_FREE, id, r);
            else
                queue_op($urandom_range(1) ? hpool_pkg::OP_UNLOCK : hpool_pkg::OP_UNLOCK_LAST,
                         id, r);
        end
        wait_idle();

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (predicted_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_results.size());
            errors++;
        end
        $display("covered %0d request beats and %0d checked results across five idling phases",
                 n_accepted, n_checked);
        $display("ok %0d, full %0d, invalid %0d, stale %0d, unallocated %0d, unlocked %0d, %s",
                 status_seen[hpool_pkg::ST_OK], status_seen[hpool_pkg::ST_FULL],
                 status_seen[hpool_pkg::ST_INVALID], status_seen[hpool_pkg::ST_STALE],
                 status_seen[hpool_pkg::ST_NOTALLOC], status_seen[hpool_pkg::ST_NOTLOCKED],
                 $sformatf("locked %0d, saturated %0d, not last %0d",
                           status_seen[hpool_pkg::ST_LOCKED], status_seen[hpool_pkg::ST_SAT],
                           status_seen[hpool_pkg::ST_NOTLAST]));
        if (errors == 0)
            $display("refcounted_handle_pool_core regression: pass");
        else
            $display("refcounted_handle_pool_core regression: fail");
        $finish;
    end

endmodule
